[rtl/core/flc_pkg.sv]
// Shared constants and types of the full linear convolution block.
`timescale 1ns / 1ps

package flc_pkg;

   // Payload widths
   localparam int VALUE_W      = 16;
   localparam int COEF_IDX_W   = 6;
   localparam int TAP_COUNT_W  = 7;
   localparam int TAIL_W       = TAP_COUNT_W - 1;
   localparam int PROD_W       = 2 * VALUE_W;
   localparam int Y_W          = 37;

   localparam int DEFAULT_MAX_TAPS = 64;

   // Command codes
   localparam logic CMD_LOAD_COEF = 1'b0;
   localparam logic CMD_SAMPLE    = 1'b1;

   // Register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] REG_TAP_COUNT = '0;
   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = TAP_COUNT_W'(1);

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COEF_IDX_W-1:0]     coef_idx_type;
   typedef logic signed [Y_W-1:0]     y_type;

   localparam y_type Y_MAX = {1'b0, {(Y_W - 1){1'b1}}};
   localparam y_type Y_MIN = {1'b1, {(Y_W - 1){1'b0}}};

endpackage

[rtl/core/flc_channels.sv]
// Valid/ready channel interfaces for commands in and results out.
`timescale 1ns / 1ps

interface flc_req_if;
   import flc_pkg::*;

   logic         valid;
   logic         ready;
   logic         command;
   coef_idx_type coef_index;
   value_type    value;
   logic         last_sample;

   modport source (output valid, output command, output coef_index, output value,
                   output last_sample, input ready);
   modport sink   (input valid, input command, input coef_index, input value,
                   input last_sample, output ready);
endinterface

interface flc_rsp_if;
   import flc_pkg::*;

   logic  valid;
   logic  ready;
   y_type y_value;
   logic  last_output;

   modport source (output valid, output y_value, output last_output, input ready);
   modport sink   (input valid, input y_value, input last_output, output ready);
endinterface

[rtl/core/full_linear_convolution.sv]
// Full linear convolution engine: delay line, parallel products, registered adder tree.
`timescale 1ns / 1ps

// Takes one command per clock unless tail results are pending or the result side stalls. A
// coefficient load writes the store and yields no result; a sample shifts into the delay
// line and yields one result, computed by one multiplier per tap in parallel followed by a
// registered adder tree of log2(MAX_TAPS) levels. A sample marked last is followed by the
// effective tap count less one tail results, one per cycle unless the pipeline stalls,
// during which no command is taken; the delay line is then cleared to zero. tap_count of
// zero acts as one tap and values above MAX_TAPS act as MAX_TAPS. Write tap_count only
// while no sequence is in flight.
module full_linear_convolution #(
   parameter int MAX_TAPS = flc_pkg::DEFAULT_MAX_TAPS
) (
   input  logic                            clock,
   input  logic                            reset,
   flc_req_if.sink                         req_chan,
   flc_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [flc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [flc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [flc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import flc_pkg::*;

   localparam int LEVELS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int NPAD   = 1 << LEVELS;
   localparam int SUM_W  = PROD_W + LEVELS;
   localparam int CMP_W  = SUM_W + Y_W;
   // stage 0 holds the delay line, stage 1 the products, the rest the tree levels
   localparam int NST    = LEVELS + 2;

   localparam logic signed [CMP_W-1:0] Y_MAX_X = CMP_W'(Y_MAX);
   localparam logic signed [CMP_W-1:0] Y_MIN_X = CMP_W'(Y_MIN);

   // ---------------- register port ----------------
   logic [TAP_COUNT_W-1:0] tap_count_ff;
   logic [TAP_COUNT_W-1:0] tap_count_in;
   logic                   csr_hit;
   logic                   csr_wr;
   logic [TAP_COUNT_W-1:0] taps_w;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_ADDR_W-1:2] == REG_TAP_COUNT;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(tap_count_ff) : '0;

   always_comb begin
      tap_count_in = csr_wr ? csr_pwdata[TAP_COUNT_W-1:0] : tap_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   always_comb begin
      priority if (tap_count_ff == '0) begin
         taps_w = TAP_COUNT_W'(1);
      end else if (tap_count_ff > TAP_COUNT_W'(MAX_TAPS)) begin
         taps_w = TAP_COUNT_W'(MAX_TAPS);
      end else begin
         taps_w = tap_count_ff;
      end
   end

   // ---------------- pipeline control ----------------
   logic [NST-1:0]    vld_ff;
   logic [NST-1:0]    vld_in;
   logic [NST-1:0]    last_ff;
   logic [NST-1:0]    last_in;
   logic [NST-1:0]    adv;
   logic              out_free;
   logic              stage0_free;
   logic              req_take;
   logic              sample_go;
   logic              load_go;
   logic              tail_go;
   logic              shift_go;
   logic              clear_go;
   logic              new_last;
   logic [TAIL_W-1:0] tail_cnt_ff;
   logic [TAIL_W-1:0] tail_cnt_in;
   logic [TAP_COUNT_W-1:0] taps_m1;
   value_type         shift_data;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   y_type             rsp_y_ff;
   y_type             rsp_y_in;
   logic              rsp_last_ff;

   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign adv[NST-1]   = vld_ff[NST-1] && out_free;

   for (genvar s = 0; s < NST - 1; s++) begin : g_adv
      assign adv[s] = vld_ff[s] && (!vld_ff[s+1] || adv[s+1]);
   end

   assign stage0_free    = !vld_ff[0] || adv[0];
   assign req_chan.ready = (tail_cnt_ff == '0) && stage0_free;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign sample_go      = req_take && (req_chan.command == CMD_SAMPLE);
   assign load_go        = req_take && (req_chan.command == CMD_LOAD_COEF);
   assign tail_go        = (tail_cnt_ff != '0) && stage0_free;
   assign shift_go       = sample_go || tail_go;
   // the final output of a sequence leaves stage 0: wipe the delay line behind it
   assign clear_go       = adv[0] && last_ff[0];
   assign shift_data     = sample_go ? req_chan.value : '0;
   assign taps_m1        = taps_w - TAP_COUNT_W'(1);

   always_comb begin
      if (sample_go) begin
         new_last = req_chan.last_sample && (taps_w == TAP_COUNT_W'(1));
      end else begin
         new_last = tail_cnt_ff == TAIL_W'(1);
      end
   end

   always_comb begin
      priority if (sample_go && req_chan.last_sample) begin
         tail_cnt_in = taps_m1[TAIL_W-1:0];
      end else if (tail_go) begin
         tail_cnt_in = tail_cnt_ff - TAIL_W'(1);
      end else begin
         tail_cnt_in = tail_cnt_ff;
      end
   end

   always_comb begin
      vld_in[0]  = shift_go || (vld_ff[0] && !adv[0]);
      last_in[0] = shift_go ? new_last : last_ff[0];
      for (int s = 1; s < NST; s++) begin
         vld_in[s]  = adv[s-1] || (vld_ff[s] && !adv[s]);
         last_in[s] = adv[s-1] ? last_ff[s-1] : last_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         last_ff     <= '0;
         tail_cnt_ff <= '0;
      end else begin
         vld_ff      <= vld_in;
         last_ff     <= last_in;
         tail_cnt_ff <= tail_cnt_in;
      end
   end

   // ---------------- coefficient store ----------------
   value_type coef_ff [MAX_TAPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{default: '0};
      end else begin
         for (int k = 0; k < MAX_TAPS; k++) begin
            if (load_go && (req_chan.coef_index == COEF_IDX_W'(k))) begin
               coef_ff[k] <= req_chan.value;
            end
         end
      end
   end

   // ---------------- sample delay line ----------------
   value_type delay_ff   [MAX_TAPS];
   value_type delay_in   [MAX_TAPS];
   value_type delay_base [MAX_TAPS];

   always_comb begin
      for (int k = 0; k < MAX_TAPS; k++) begin
         delay_base[k] = clear_go ? '0 : delay_ff[k];
      end
      delay_in = delay_base;
      if (shift_go) begin
         delay_in[0] = shift_data;
         for (int k = 1; k < MAX_TAPS; k++) begin
            delay_in[k] = delay_base[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '{default: '0};
      end else begin
         delay_ff <= delay_in;
      end
   end

   // ---------------- products and adder tree ----------------
   // heap order: node i sums nodes 2i and 2i+1, leaves sit at NPAD and up
   logic signed [SUM_W-1:0] node_ff [1:2*NPAD-1];

   for (genvar k = 0; k < NPAD; k++) begin : g_lane
      if (k < MAX_TAPS) begin : g_tap
         value_type               coef_use;
         logic signed [PROD_W-1:0] prod;

         always_comb begin
            coef_use = (TAP_COUNT_W'(k) < taps_w) ? coef_ff[k] : '0;
            prod     = coef_use * delay_ff[k];
         end

         always_ff @(posedge clock) begin
            if (adv[0]) begin
               node_ff[NPAD+k] <= SUM_W'(prod);
            end
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            if (adv[0]) begin
               node_ff[NPAD+k] <= '0;
            end
         end
      end
   end

   for (genvar i = 1; i < NPAD; i++) begin : g_node
      localparam int DEPTH = $clog2(i + 1) - 1;

      always_ff @(posedge clock) begin
         if (adv[LEVELS-DEPTH]) begin
            node_ff[i] <= node_ff[2*i] + node_ff[2*i+1];
         end
      end
   end

   // ---------------- saturation and result register ----------------
   logic signed [CMP_W-1:0] root_x;

   assign root_x = CMP_W'(node_ff[1]);

   always_comb begin
      priority if (root_x > Y_MAX_X) begin
         rsp_y_in = Y_MAX;
      end else if (root_x < Y_MIN_X) begin
         rsp_y_in = Y_MIN;
      end else begin
         rsp_y_in = root_x[Y_W-1:0];
      end
   end

   assign rsp_valid_in = adv[NST-1] || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NST-1]) begin
         rsp_y_ff    <= rsp_y_in;
         rsp_last_ff <= last_ff[NST-1];
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.y_value     = rsp_y_ff;
   assign rsp_chan.last_output = rsp_last_ff;

   // ---------------- checks ----------------
   a_tail_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (tail_cnt_ff != '0) |-> !req_chan.ready)
      else $error("command taken while tail outputs pending");

   a_last_ends_tail: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && last_ff[0]) |-> (tail_cnt_ff == '0))
      else $error("final output launched with tail still pending");

   a_tail_launches: assert property (@(posedge clock) disable iff (reset)
      tail_go |=> vld_ff[0])
      else $error("tail step did not enter the delay stage");

endmodule

[tb/full_linear_convolution_test.sv]
// Self-checking testbench for the full linear convolution block.
`timescale 1ns / 1ps

module full_linear_convolution_test;
   import flc_pkg::*;

   localparam int TAPS_MAX     = DEFAULT_MAX_TAPS;
   localparam int DRAIN_CYCLES = 32;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam logic [CSR_ADDR_W-1:0] TAP_COUNT_ADDR = {REG_TAP_COUNT, 2'b00};

   typedef struct {
      y_type y;
      logic  last;
   } y_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   flc_req_if req_if ();
   flc_rsp_if rsp_if ();

   full_linear_convolution u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor state
   value_type        coef_mem [TAPS_MAX];
   value_type        sample_line [TAPS_MAX];
   logic [TAP_COUNT_W-1:0] tap_setting;
   y_result_type     expected_outputs [$];

   int error_count    = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic int taps_in_use();
      if (tap_setting == 0)
         return 1;
      if (tap_setting > TAPS_MAX)
         return TAPS_MAX;
      return int'(tap_setting);
   endfunction

   function automatic void shift_sample(input value_type s);
      for (int k = TAPS_MAX - 1; k > 0; k--)
         sample_line[k] = sample_line[k-1];
      sample_line[0] = s;
   endfunction

   function automatic y_type tap_sum(input int taps);
      longint acc;
      acc = 0;
      for (int k = 0; k < taps; k++)
         acc += longint'(coef_mem[k]) * longint'(sample_line[k]);
      if (acc > longint'(Y_MAX))
         acc = longint'(Y_MAX);
      if (acc < longint'(Y_MIN))
         acc = longint'(Y_MIN);
      return y_type'(acc);
   endfunction

   function automatic void predict_convolution(input logic cmd, input coef_idx_type idx,
                                               input value_type val, input logic last);
      int           taps;
      y_result_type r;
      if (cmd == CMD_LOAD_COEF) begin
         coef_mem[idx] = val;
         return;
      end
      taps = taps_in_use();
      shift_sample(val);
      r.y    = tap_sum(taps);
      r.last = last && (taps == 1);
      expected_outputs.push_back(r);
      if (last) begin
         // tail: flush with zeros, then clear the line
         for (int t = 1; t < taps; t++) begin
            shift_sample('0);
            r.y    = tap_sum(taps);
            r.last = (t == taps - 1);
            expected_outputs.push_back(r);
         end
         for (int k = 0; k < TAPS_MAX; k++)
            sample_line[k] = '0;
      end
   endfunction

   // Leaves valid high after the transfer; wait_drain drops it, as does the next call when it idles first.
   task automatic send_item(input logic cmd, input coef_idx_type idx, input value_type val,
                            input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid       <= 1'b1;
      req_if.command     <= cmd;
      req_if.coef_index  <= idx;
      req_if.value       <= val;
      req_if.last_sample <= last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_convolution(cmd, idx, val, last);
   endtask

   task automatic wait_drain();
      req_if.valid <= 1'b0;
      while (expected_outputs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_taps(input logic [CSR_DATA_W-1:0] data);
      wait_drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TAP_COUNT_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tap_setting = data[TAP_COUNT_W-1:0];
   endtask

   function automatic value_type rand_value();
      case ($urandom_range(7))
         0: return value_type'(16'sh8000);
         1: return value_type'(16'sh7FFF);
         default: return value_type'($urandom);
      endcase
   endfunction

   // Receiver: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_outputs
      y_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected output y_value=%0d", rsp_if.y_value));
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_if.y_value !== want.y)
               report_mismatch($sformatf("y_value %0d, predicted %0d",
                                         rsp_if.y_value, want.y));
            if (rsp_if.last_output !== want.last)
               report_mismatch($sformatf("last_output %b, predicted %b",
                                         rsp_if.last_output, want.last));
         end
      end
   end

   // Reset tap count, single tap, stray last flag on a coefficient load
   task automatic test_single_tap();
      send_item(CMD_SAMPLE, '0, 16'sh7FFF, 1'b0);
      send_item(CMD_LOAD_COEF, 6'd0, 16'sh8000, 1'b1);
      send_item(CMD_SAMPLE, 6'h3F, 16'sh8000, 1'b0);
      send_item(CMD_SAMPLE, '0, 16'sh7FFF, 1'b0);
      send_item(CMD_SAMPLE, '0, 16'sh0000, 1'b0);
      send_item(CMD_SAMPLE, '0, 16'sh8000, 1'b1);
      send_item(CMD_LOAD_COEF, 6'h3F, 16'sh7FFF, 1'b0);
   endtask

   task automatic test_tap_limits();
      set_taps(32'd0);
      send_item(CMD_LOAD_COEF, 6'd0, 16'sh4000, 1'b0);
      send_item(CMD_SAMPLE, '0, 16'sd100, 1'b0);
      send_item(CMD_SAMPLE, '0, -16'sd1, 1'b1);
      // upper data bits lie outside the register
      set_taps(32'hFFFF_FF83);
      send_item(CMD_LOAD_COEF, 6'd1, 16'sh7FFF, 1'b0);
      send_item(CMD_LOAD_COEF, 6'd2, 16'sh8000, 1'b0);
      send_item(CMD_SAMPLE, '0, 16'sd1, 1'b0);
      send_item(CMD_SAMPLE, '0, 16'sd2, 1'b0);
      send_item(CMD_SAMPLE, '0, 16'sd3, 1'b1);
      set_taps(32'd127);
      send_item(CMD_SAMPLE, '0, 16'sd7, 1'b1);
   endtask

   task automatic test_coef_reload_mid_sequence();
      set_taps(32'd4);
      for (int k = 0; k < 4; k++)
         send_item(CMD_LOAD_COEF, coef_idx_type'(k), rand_value(), 1'b0);
      for (int i = 0; i < 3; i++)
         send_item(CMD_SAMPLE, '0, rand_value(), 1'b0);
      send_item(CMD_LOAD_COEF, 6'd1, rand_value(), 1'b0);
      send_item(CMD_SAMPLE, '0, rand_value(), 1'b0);
      send_item(CMD_SAMPLE, '0, rand_value(), 1'b1);
   endtask

   // Every product at (-32768)*(-32768) over 64 taps reaches +2^36 and clips
   task automatic test_saturation();
      set_taps(32'd64);
      for (int k = 0; k < TAPS_MAX; k++)
         send_item(CMD_LOAD_COEF, coef_idx_type'(k), 16'sh8000, 1'b0);
      for (int i = 0; i < TAPS_MAX; i++)
         send_item(CMD_SAMPLE, '0, 16'sh8000, i == TAPS_MAX - 1);
      send_item(CMD_SAMPLE, '0, 16'sh7FFF, 1'b0);
      send_item(CMD_SAMPLE, '0, 16'sh7FFF, 1'b1);
   endtask

   // Hold the result side off long enough for the block to stall its input
   task automatic test_input_stall();
      set_taps(32'd8);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 300;
      for (int i = 0; i < 16; i++)
         send_item(CMD_SAMPLE, coef_idx_type'($urandom), rand_value(), i == 15);
   endtask

   task automatic test_random_sequences();
      int sent;
      int taps;
      int len;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         case ($urandom_range(7))
            0: set_taps(32'd64);
            1: set_taps(32'd0);
            2: set_taps($urandom_range(127, 65));
            default: set_taps($urandom_range(8, 1));
         endcase
         taps = taps_in_use();
         sent = 0;
         while (sent < 8) begin
            if ($urandom_range(9) == 0) begin
               // stray load anywhere in the store, last flag random
               send_item(CMD_LOAD_COEF, coef_idx_type'($urandom_range(63)), rand_value(),
                         logic'($urandom_range(1)));
               sent++;
            end else begin
               repeat ($urandom_range(2)) begin
                  send_item(CMD_LOAD_COEF, coef_idx_type'($urandom_range(taps - 1)),
                            rand_value(), 1'b0);
                  sent++;
               end
               len = $urandom_range(6, 1);
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(9) == 0) begin
                     send_item(CMD_LOAD_COEF, coef_idx_type'($urandom_range(taps - 1)),
                               rand_value(), 1'b0);
                     sent++;
                  end
                  // now and then leave the sequence open so it runs on
                  send_item(CMD_SAMPLE, coef_idx_type'($urandom), rand_value(),
                            (i == len - 1) && ($urandom_range(7) != 0));
                  sent++;
               end
            end
         end
         // close any open sequence before the next register write
         send_item(CMD_SAMPLE, coef_idx_type'($urandom), rand_value(), 1'b1);
      end
   endtask

   initial begin
      req_if.valid       = 1'b0;
      req_if.command     = CMD_LOAD_COEF;
      req_if.coef_index  = '0;
      req_if.value       = '0;
      req_if.last_sample = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      tap_setting        = TAP_COUNT_RESET;
      for (int k = 0; k < TAPS_MAX; k++) begin
         coef_mem[k]    = '0;
         sample_line[k] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_tap();
      test_tap_limits();
      test_coef_reload_mid_sequence();
      test_saturation();
      test_input_stall();
      test_random_sequences();

      wait_drain();
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
